// File: rtl/hir_pkg.sv
// Shared widths, pipeline sizes and Q32 regression coefficients for the heat index block.
package hir_pkg;

    localparam int FRAC_BITS_DEF = 8;

    // Port field widths
    localparam int T_IN_W = 17;
    localparam int H_IN_W = 15;
    localparam int HI_W   = 18;

    // Internal Q16 operand widths after clamping
    localparam int T_W = 25;
    localparam int H_W = 24;

    // Square root pipeline: 25 root bits, 5 per stage
    localparam int SQRT_W      = 25;
    localparam int SQRT_STEP   = 5;
    localparam int SQRT_STAGES = SQRT_W / SQRT_STEP;

    localparam longint ONE16 = 64'sd65536;
    localparam longint ONE48 = 64'sd1 <<< 48;
    localparam longint TWO32 = 64'sd4294967296;

    // Coefficients, Q32, rounded to nearest; C_BASE is then scaled to Q48
    localparam longint C_12   = (64'sd12 * TWO32 + 64'sd5) / 64'sd10;
    localparam longint C_094  = (64'sd94 * TWO32 + 64'sd500) / 64'sd1000;
    localparam longint C_BASE = -(((64'sd42379 * TWO32 + 64'sd500) / 64'sd1000) * ONE16);
    localparam longint C_T    = (64'sd204901523 * TWO32 + 64'sd50000000) / 64'sd100000000;
    localparam longint C_H    = (64'sd1014333127 * TWO32 + 64'sd50000000) / 64'sd100000000;
    localparam longint C_TH   = (64'sd22475541 * TWO32 + 64'sd50000000) / 64'sd100000000;
    localparam longint C_TT   = (64'sd683783 * TWO32 + 64'sd50000000) / 64'sd100000000;
    localparam longint C_HH   = (64'sd5481717 * TWO32 + 64'sd50000000) / 64'sd100000000;
    localparam longint C_TTH  = (64'sd122874 * TWO32 + 64'sd50000000) / 64'sd100000000;
    localparam longint C_THH  = (64'sd85282 * TWO32 + 64'sd50000000) / 64'sd100000000;
    localparam longint C_TTHH = (64'sd199 * TWO32 + 64'sd50000000) / 64'sd100000000;
    localparam longint C_SQ   = (64'sd5882 * TWO32 + 64'sd50000) / 64'sd100000;
    localparam longint C_02   = (64'sd2 * TWO32 + 64'sd50) / 64'sd100;

    // Simple estimate (before halving) above this selects the regression
    localparam longint HOT_LIM = 64'sd158 * ONE48 + 64'sd1;

endpackage

// File: rtl/hir_isqrt.sv
// Pipelined integer square root, a fixed number of root bits per stage.
module hir_isqrt #(
    parameter int ROOT_W    = hir_pkg::SQRT_W,
    parameter int STEP_BITS = hir_pkg::SQRT_STEP
) (
    input  logic                  clk,
    input  logic                  ce,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic [ROOT_W-1:0]     root
);
    localparam int STAGES = ROOT_W / STEP_BITS;
    localparam int REM_W  = ROOT_W + 2;
    localparam int RAD_W  = 2 * ROOT_W;

    logic [REM_W-1:0]  rem_in  [STAGES];
    logic [ROOT_W-1:0] root_in [STAGES];
    logic [RAD_W-1:0]  rad_in  [STAGES];

    logic [REM_W-1:0]  rem_next  [STAGES];
    logic [ROOT_W-1:0] root_next [STAGES];
    logic [RAD_W-1:0]  rad_next  [STAGES];

    logic [ROOT_W-1:0] root_reg [STAGES];

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_stage
            if (g == 0) begin : g_first
                assign rem_in[g]  = '0;
                assign root_in[g] = '0;
                assign rad_in[g]  = radicand;
            end else begin : g_rest
                logic [REM_W-1:0] rem_reg;
                logic [RAD_W-1:0] rad_reg;

                always_ff @(posedge clk)
                begin
                    if (ce)
                    begin
                        rem_reg <= rem_next[g-1];
                        rad_reg <= rad_next[g-1];
                    end
                end

                assign rem_in[g]  = rem_reg;
                assign root_in[g] = root_reg[g-1];
                assign rad_in[g]  = rad_reg;
            end

            // restoring digit recurrence, one root bit per step
            always_comb
            begin
                logic [REM_W-1:0]  rem;
                logic [ROOT_W-1:0] rt;
                logic [RAD_W-1:0]  rad;
                logic [REM_W-1:0]  trial;
                rem = rem_in[g];
                rt  = root_in[g];
                rad = rad_in[g];
                for (int j = 0; j < STEP_BITS; j++)
                begin
                    rem   = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
                    rad   = {rad[RAD_W-3:0], 2'b00};
                    trial = {rt, 2'b01};
                    if (rem >= trial)
                    begin
                        rem = rem - trial;
                        rt  = {rt[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rt  = {rt[ROOT_W-2:0], 1'b0};
                    end
                end
                rem_next[g]  = rem;
                root_next[g] = rt;
                rad_next[g]  = rad;
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    root_reg[g] <= root_next[g];
                end
            end
        end
    endgenerate

    assign root = root_reg[STAGES-1];

endmodule

// File: rtl/heat_index_rothfusz.sv
// Heat index (Steadman estimate, Rothfusz regression, humidity corrections), pipelined.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------
//  sample   | sample_valid / sample_stall | temp_f, rel_humidity
//  result   | result_valid / result_stall | heat_index_f, clipped
//
// One transaction per cycle while no result stall holds the pipeline. The depth is
// set by the square root pipeline of the low-humidity correction.
// Reset clears only the valid bits; no payload register is reset.
// A stall on a valid result freezes the whole pipeline and is passed back
// as sample_stall in the same cycle; nothing is dropped or repeated.
module heat_index_rothfusz #(
    parameter int FRAC_BITS = hir_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic signed [hir_pkg::T_IN_W-1:0]  temp_f,
    input  logic [hir_pkg::H_IN_W-1:0]         rel_humidity,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [hir_pkg::HI_W-1:0]    heat_index_f,
    output logic                               clipped
);
    import hir_pkg::*;

    localparam int NS     = SQRT_STAGES;
    localparam int LAT    = NS + 6;
    localparam int RES_W  = FRAC_BITS + 20;
    localparam int SH_IN  = 16 - FRAC_BITS;
    localparam int SH_OUT = 48 - FRAC_BITS;

    localparam longint HI_RAW  = 64'sd400 <<< FRAC_BITS;
    localparam longint LO_RAW  = -(64'sd100 <<< FRAC_BITS);
    localparam longint SAT_MAX = (64'sd1 <<< (HI_W - 1)) - 64'sd1;
    localparam longint SAT_MIN = -(64'sd1 <<< (HI_W - 1));
    localparam longint SAT_HI  = (HI_RAW > SAT_MAX) ? SAT_MAX : HI_RAW;
    localparam longint SAT_LO  = (LO_RAW < SAT_MIN) ? SAT_MIN : LO_RAW;

    // Stage 1: clamped Q16 operands
    typedef struct packed {
        logic signed [T_W-1:0] t;
        logic signed [H_W-1:0] h;
    } s1_t;

    // Stage 2: first products, simple-estimate terms, correction inputs
    typedef struct packed {
        logic signed [T_W-1:0] t;
        logic signed [H_W-1:0] h;
        logic signed [31:0]    tt;
        logic signed [31:0]    th;
        logic signed [30:0]    hh;
        logic signed [63:0]    p12;
        logic signed [63:0]    p094;
        logic [20:0]           d;
        logic signed [24:0]    hm;
        logic signed [24:0]    tm;
        logic [19:0]           a;
        logic                  low;
        logic                  high;
    } s2_t;

    // Stage 3: third- and fourth-order products
    typedef struct packed {
        logic signed [T_W-1:0] t;
        logic signed [H_W-1:0] h;
        logic signed [31:0]    tt;
        logic signed [31:0]    th;
        logic signed [30:0]    hh;
        logic signed [38:0]    tth;
        logic signed [37:0]    thh;
        logic signed [44:0]    tthh;
        logic signed [30:0]    p;
        logic [2*SQRT_W-1:0]   sq;
    } s3_t;

    // Travels beside the regression and the square root
    typedef struct packed {
        logic signed [63:0] simple;
        logic [19:0]        a;
        logic               low;
        logic               high;
    } side_t;

    // Stage 4: coefficient products
    typedef struct packed {
        logic signed [63:0] m_t;
        logic signed [63:0] m_h;
        logic signed [63:0] m_th;
        logic signed [63:0] m_tt;
        logic signed [63:0] m_hh;
        logic signed [63:0] m_tth;
        logic signed [63:0] m_thh;
        logic signed [63:0] m_tthh;
        logic signed [63:0] m_p;
    } s4_t;

    // Stage 5: partial sums
    typedef struct packed {
        logic signed [63:0] e0;
        logic signed [63:0] e1;
        logic signed [63:0] e2;
        logic signed [63:0] eh;
    } s5_t;

    // Stage after the root: low-humidity product and selection flags
    typedef struct packed {
        logic [SQRT_W+19:0] as;
        logic signed [63:0] acc;
        logic signed [63:0] simple;
        logic               hot;
        logic               low;
    } s9_t;

    logic ce;
    logic [LAT-1:0] vld_reg, vld_next;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    s9_t s9_reg, s9_next;
    side_t side_reg [NS+1];
    side_t side_next [NS+1];
    logic signed [63:0] acc_reg [NS-2];
    logic signed [63:0] acc_next [NS-2];
    logic signed [RES_W-1:0] res_reg, res_next;
    logic signed [HI_W-1:0] heat_index_f_reg, heat_index_f_next;
    logic clipped_reg, clipped_next;
    logic [SQRT_W-1:0] root;

    // Whole pipeline advances unless the result register is full and stalled
    assign ce           = !(vld_reg[LAT-1] && result_stall);
    assign sample_stall = !ce;
    assign result_valid = vld_reg[LAT-1];
    assign heat_index_f = heat_index_f_reg;
    assign clipped      = clipped_reg;

    assign vld_next = {vld_reg[LAT-2:0], sample_valid};

    // Stage 1: scale to Q16 and clamp temperature to [-40, 150], humidity to 100
    always_comb
    begin
        longint ts;
        longint hs;
        ts = longint'(temp_f) <<< SH_IN;
        hs = longint'(rel_humidity) <<< SH_IN;
        if (ts < -64'sd40 * ONE16)
            ts = -64'sd40 * ONE16;
        if (ts > 64'sd150 * ONE16)
            ts = 64'sd150 * ONE16;
        if (hs > 64'sd100 * ONE16)
            hs = 64'sd100 * ONE16;
        s1_next.t = T_W'(ts);
        s1_next.h = H_W'(hs);
    end

    // Stage 2: T*T, T*RH, RH*RH back to Q16 (floor), estimate terms, windows
    always_comb
    begin
        logic signed [49:0] tt_f;
        logic signed [48:0] th_f;
        logic signed [47:0] hh_f;
        longint tl;
        longint hl;
        longint dev;
        longint dv;
        tt_f = s1_reg.t * s1_reg.t;
        th_f = s1_reg.t * s1_reg.h;
        hh_f = s1_reg.h * s1_reg.h;
        tl   = longint'(s1_reg.t);
        hl   = longint'(s1_reg.h);
        dev  = tl - 64'sd95 * ONE16;
        if (dev < 0)
            dev = -dev;
        dv = 64'sd17 * ONE16 - dev;
        if (dv < 0)
            dv = 0;
        s2_next.t    = s1_reg.t;
        s2_next.h    = s1_reg.h;
        s2_next.tt   = tt_f[47:16];
        s2_next.th   = th_f[47:16];
        s2_next.hh   = hh_f[46:16];
        s2_next.p12  = (tl - 64'sd68 * ONE16) * C_12;
        s2_next.p094 = hl * C_094;
        s2_next.d    = 21'(dv);
        s2_next.hm   = 25'(hl - 64'sd85 * ONE16);
        s2_next.tm   = 25'(64'sd87 * ONE16 - tl);
        s2_next.a    = 20'(64'sd13 * ONE16 - hl);
        s2_next.low  = (hl < 64'sd13 * ONE16) && (tl >= 64'sd80 * ONE16)
                       && (tl <= 64'sd112 * ONE16);
        s2_next.high = (hl > 64'sd85 * ONE16) && (tl >= 64'sd80 * ONE16)
                       && (tl <= 64'sd87 * ONE16);
    end

    // Stage 3: third- and fourth-order products, root radicand, simple estimate
    always_comb
    begin
        logic signed [55:0] tth_f;
        logic signed [55:0] thh_f;
        logic signed [62:0] tthh_f;
        logic signed [49:0] p_f;
        tth_f  = s2_reg.tt * s2_reg.h;
        thh_f  = s2_reg.t * s2_reg.hh;
        tthh_f = s2_reg.tt * s2_reg.hh;
        p_f    = s2_reg.hm * s2_reg.tm;
        s3_next.t    = s2_reg.t;
        s3_next.h    = s2_reg.h;
        s3_next.tt   = s2_reg.tt;
        s3_next.th   = s2_reg.th;
        s3_next.hh   = s2_reg.hh;
        s3_next.tth  = tth_f[54:16];
        s3_next.thh  = thh_f[53:16];
        s3_next.tthh = tthh_f[60:16];
        s3_next.p    = p_f[46:16];
        s3_next.sq   = (2*SQRT_W)'(longint'(s2_reg.d) * C_SQ);

        side_next[0].simple = (longint'(s2_reg.t) <<< 32) + 64'sd61 * ONE48
                              + s2_reg.p12 + s2_reg.p094;
        side_next[0].a      = s2_reg.a;
        side_next[0].low    = s2_reg.low;
        side_next[0].high   = s2_reg.high;
        for (int k = 1; k <= NS; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
    end

    // Stage 4: one coefficient multiply per term
    always_comb
    begin
        s4_next.m_t    = longint'(s3_reg.t) * C_T;
        s4_next.m_h    = longint'(s3_reg.h) * C_H;
        s4_next.m_th   = longint'(s3_reg.th) * C_TH;
        s4_next.m_tt   = longint'(s3_reg.tt) * C_TT;
        s4_next.m_hh   = longint'(s3_reg.hh) * C_HH;
        s4_next.m_tth  = longint'(s3_reg.tth) * C_TTH;
        s4_next.m_thh  = longint'(s3_reg.thh) * C_THH;
        s4_next.m_tthh = longint'(s3_reg.tthh) * C_TTHH;
        s4_next.m_p    = longint'(s3_reg.p) * C_02;
    end

    // Stage 5/6: regression sum, high-humidity term folded in
    always_comb
    begin
        s5_next.e0 = C_BASE + s4_reg.m_t + s4_reg.m_h;
        s5_next.e1 = s4_reg.m_tth + s4_reg.m_thh - s4_reg.m_th;
        s5_next.e2 = -(s4_reg.m_tt + s4_reg.m_hh + s4_reg.m_tthh);
        s5_next.eh = side_reg[1].high ? s4_reg.m_p : 64'sd0;

        acc_next[0] = s5_reg.e0 + s5_reg.e1 + s5_reg.e2 + s5_reg.eh;
        for (int k = 1; k < NS - 2; k++)
        begin
            acc_next[k] = acc_reg[k-1];
        end
    end

    hir_isqrt #(
        .ROOT_W    (SQRT_W),
        .STEP_BITS (SQRT_STEP)
    ) u_isqrt (
        .clk      (clk),
        .ce       (ce),
        .radicand (s3_reg.sq),
        .root     (root)
    );

    // Root is aligned with the delayed regression sum here
    always_comb
    begin
        s9_next.as     = side_reg[NS].a * root;
        s9_next.acc    = acc_reg[NS-3];
        s9_next.simple = side_reg[NS].simple;
        s9_next.hot    = side_reg[NS].simple > HOT_LIM;
        s9_next.low    = side_reg[NS].low;
    end

    // Select path, apply low-humidity correction, drop to FRAC_BITS (floor)
    always_comb
    begin
        longint sel;
        if (s9_reg.hot)
        begin
            sel = s9_reg.acc;
            if (s9_reg.low)
                sel = s9_reg.acc - (longint'(s9_reg.as) <<< 6);
        end
        else
        begin
            sel = s9_reg.simple >>> 1;
        end
        res_next = RES_W'(sel >>> SH_OUT);
    end

    // Saturate and flag
    always_comb
    begin
        longint r;
        r = longint'(res_reg);
        clipped_next = 1'b0;
        if (r < SAT_LO)
        begin
            r = SAT_LO;
            clipped_next = 1'b1;
        end
        if (r > SAT_HI)
        begin
            r = SAT_HI;
            clipped_next = 1'b1;
        end
        heat_index_f_next = HI_W'(r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_reg           <= s1_next;
            s2_reg           <= s2_next;
            s3_reg           <= s3_next;
            s4_reg           <= s4_next;
            s5_reg           <= s5_next;
            side_reg         <= side_next;
            acc_reg          <= acc_next;
            s9_reg           <= s9_next;
            res_reg          <= res_next;
            heat_index_f_reg <= heat_index_f_next;
            clipped_reg      <= clipped_next;
        end
    end

endmodule

// File: tb/heat_index_rothfusz_tb.sv
// Self-checking testbench for the heat index block: directed table plus random samples.
module heat_index_rothfusz_tb;
    import hir_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int N_RANDOM  = 1100;
    localparam int LATENCY   = SQRT_STAGES + 6;
    localparam longint CYCLE_LIMIT = 400000;

    // Temperature and humidity limits in input LSBs
    localparam int T_MIN_F = -40 <<< FB;
    localparam int T_MAX_F = 150 <<< FB;
    localparam int RH_FULL = 100 <<< FB;

    typedef struct {
        logic signed [T_IN_W-1:0] temp;
        logic [H_IN_W-1:0]        rh;
        bit                       known;   // expected result typed in
        logic signed [HI_W-1:0]   hi;
        logic                     clip;
    } sample_row_t;

    typedef struct {
        logic signed [HI_W-1:0] hi;
        logic                   clip;
    } heat_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      sample_valid;
    logic                      sample_stall;
    logic signed [T_IN_W-1:0]  temp_f;
    logic [H_IN_W-1:0]         rel_humidity;
    logic                      result_valid;
    logic                      result_stall;
    logic signed [HI_W-1:0]    heat_index_f;
    logic                      clipped;

    heat_result_t pending_heat[$];
    sample_row_t  directed_rows[$];
    int           mismatches;
    longint       cycle_count;

    heat_index_rothfusz #(.FRAC_BITS(FB)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .temp_f       (temp_f),
        .rel_humidity (rel_humidity),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .heat_index_f (heat_index_f),
        .clipped      (clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Floor shift on signed 64-bit values (>>> is arithmetic on longint)
    function automatic longint floor_shr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    // Coefficients rounded to nearest in Q32, from decimal numerator/denominator
    function automatic longint q32(longint n, longint d);
        return (n * 64'sd4294967296 + d / 2) / d;
    endfunction

    function automatic heat_result_t heat_predict(logic signed [T_IN_W-1:0] temp,
                                                  logic [H_IN_W-1:0] rh);
        heat_result_t r;
        longint t, h, acc, res, lo, hi;
        longint tt, th, hh, tth, thh, tthh, dev, d, s, p;
        t = longint'(temp) * (64'sd1 <<< (16 - FB));
        h = longint'({1'b0, rh}) * (64'sd1 <<< (16 - FB));
        r.clip = 1'b0;
        if (t < -40 * ONE16) t = -40 * ONE16;
        if (t > 150 * ONE16) t = 150 * ONE16;
        if (h > 100 * ONE16) h = 100 * ONE16;

        // Steadman estimate, halved with a floor shift
        acc = t * TWO32 + 61 * ONE48 + (t - 68 * ONE16) * q32(12, 10) + h * q32(94, 1000);
        acc = floor_shr(acc, 1);

        if (acc > 79 * ONE48)
        begin
            tt   = floor_shr(t * t, 16);
            th   = floor_shr(t * h, 16);
            hh   = floor_shr(h * h, 16);
            tth  = floor_shr(tt * h, 16);
            thh  = floor_shr(t * hh, 16);
            tthh = floor_shr(tt * hh, 16);
            acc = -(q32(42379, 1000) * ONE16)
                + t * q32(204901523, 100000000)
                + h * q32(1014333127, 100000000)
                - th * q32(22475541, 100000000)
                - tt * q32(683783, 100000000)
                - hh * q32(5481717, 100000000)
                + tth * q32(122874, 100000000)
                + thh * q32(85282, 100000000)
                - tthh * q32(199, 100000000);
            if (h < 13 * ONE16 && t >= 80 * ONE16 && t <= 112 * ONE16)
            begin
                dev = t - 95 * ONE16;
                if (dev < 0) dev = -dev;
                d = 17 * ONE16 - dev;
                if (d < 0) d = 0;
                s = root_floor(d * q32(5882, 100000));
                acc = acc - (13 * ONE16 - h) * s * 64;
            end
            else if (h > 85 * ONE16 && t >= 80 * ONE16 && t <= 87 * ONE16)
            begin
                p = floor_shr((h - 85 * ONE16) * (87 * ONE16 - t), 16);
                acc = acc + p * q32(2, 100);
            end
        end

        res = floor_shr(acc, 48 - FB);
        lo = -(64'sd100 <<< FB);
        hi = 64'sd400 <<< FB;
        if (lo < -131072) lo = -131072;
        if (hi > 131071) hi = 131071;
        if (res < lo) begin res = lo; r.clip = 1'b1; end
        if (res > hi) begin res = hi; r.clip = 1'b1; end
        r.hi = res[HI_W-1:0];
        return r;
    endfunction

    function automatic sample_row_t row(int temp, int rh);
        sample_row_t x;
        x.temp  = temp[T_IN_W-1:0];
        x.rh    = rh[H_IN_W-1:0];
        x.known = 1'b0;
        x.hi    = '0;
        x.clip  = 1'b0;
        return x;
    endfunction

    function automatic sample_row_t row_known(int temp, int rh, int hi, bit clip);
        sample_row_t x;
        x = row(temp, rh);
        x.known = 1'b1;
        x.hi    = hi[HI_W-1:0];
        x.clip  = clip;
        return x;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(sample_row_t x);
        heat_result_t e;
        int g;
        g = gap_len();
        // valid drops for the whole gap; with no gap it stays high back to back
        if (g != 0)
        begin
            sample_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        sample_valid <= 1'b1;
        temp_f       <= x.temp;
        rel_humidity <= x.rh;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        if (x.known)
        begin
            e.hi   = x.hi;
            e.clip = x.clip;
        end
        else
            e = heat_predict(x.temp, x.rh);
        pending_heat.push_back(e);
    endtask

    task automatic wait_drained();
        while (pending_heat.size() != 0)
            @(posedge clk);
    endtask

    // Random sample: cover the full field range, weighted toward the regression and
    // both humidity correction windows
    function automatic sample_row_t random_sample();
        int k;
        int t, h;
        k = $urandom_range(0, 9);
        case (k)
            0: begin t = $urandom_range(0, 131071) - 65536; h = $urandom_range(0, 32767); end
            1: begin t = $urandom_range(80 << FB, 112 << FB);
                     h = $urandom_range(0, (13 << FB) - 1); end
            2: begin t = $urandom_range(80 << FB, 87 << FB);
                     h = $urandom_range((85 << FB) + 1, RH_FULL); end
            3: begin t = $urandom_range(T_MIN_F - 2000, T_MIN_F + 2000);
                     h = $urandom_range(0, RH_FULL); end
            4: begin t = $urandom_range(T_MAX_F - 2000, T_MAX_F + 2000);
                     h = $urandom_range(0, 32767); end
            default: begin t = $urandom_range(70 << FB, 130 << FB);
                     h = $urandom_range(0, RH_FULL + 512); end
        endcase
        return row(t, h);
    endfunction

    // Random stall on the result side
    initial
    begin
        int g;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g != 0)
            begin
                result_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
            result_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        heat_result_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_heat.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: heat_index_f=%0d clipped=%0b",
                             heat_index_f, clipped);
            end
            else
            begin
                e = pending_heat.pop_front();
                if (heat_index_f !== e.hi || clipped !== e.clip)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: heat_index_f exp %0d got %0d, clipped exp %0b got %0b",
                                 e.hi, heat_index_f, e.clip, clipped);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        mismatches   = 0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        temp_f       = '0;
        rel_humidity = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, each branch, each saturation
        directed_rows.push_back(row(0, 0));
        directed_rows.push_back(row(-65536, 0));                  // most negative temp, clamped
        directed_rows.push_back(row(65535, 32767));               // most positive, rh clamped
        directed_rows.push_back(row(T_MIN_F, RH_FULL));
        directed_rows.push_back(row(T_MAX_F, 0));
        directed_rows.push_back(row(T_MAX_F, RH_FULL));           // hot and humid: saturates
        directed_rows.push_back(row_known(65535, 32767, 400 <<< FB, 1'b1));
        directed_rows.push_back(row(70 << FB, 50 << FB));         // Steadman only
        directed_rows.push_back(row(79 << FB, 79 << FB));         // near the switch point
        directed_rows.push_back(row(90 << FB, 40 << FB));         // regression, no correction
        directed_rows.push_back(row(95 << FB, 5 << FB));          // dry correction, peak root
        directed_rows.push_back(row(80 << FB, 0));                // dry window low edge
        directed_rows.push_back(row(112 << FB, (13 << FB) - 1));  // dry window high edge
        directed_rows.push_back(row(113 << FB, 5 << FB));         // just outside dry window
        directed_rows.push_back(row(80 << FB, RH_FULL));          // humid correction
        directed_rows.push_back(row(87 << FB, (85 << FB) + 1));   // humid window edge
        directed_rows.push_back(row(88 << FB, 95 << FB));         // just outside humid window
        directed_rows.push_back(row(100 << FB, 13 << FB));
        directed_rows.push_back(row(120 << FB, 60 << FB));
        directed_rows.push_back(row(-1, 1));
        directed_rows.push_back(row(21845, 21845));               // alternating bit patterns
        directed_rows.push_back(row(-21846, 10922));
        foreach (directed_rows[i])
            send_sample(directed_rows[i]);

        // Sender holds off until the pipe has drained
        sample_valid <= 1'b0;
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            send_sample(random_sample());
            if (n == N_RANDOM / 2)
            begin
                sample_valid <= 1'b0;
                wait_drained();
            end
        end
        sample_valid <= 1'b0;

        wait_drained();
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatches == 0 && pending_heat.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
